// ----- design/ryc_pkg.sv -----
// Shared constants, types and multiply helpers of the RGB/YUV colour converter.
`default_nettype none

package ryc_pkg;

  localparam int NumStages = 9;
  localparam int DlyLen    = NumStages - 4;

  typedef logic [NumStages-1:0] stage_vec_t;

  // BT.601 coefficients, unsigned Q2.16
  localparam logic [17:0] KY  = 18'd76284;
  localparam logic [17:0] KRV = 18'd104595;
  localparam logic [17:0] KGV = 18'd53281;
  localparam logic [17:0] KGU = 18'd25625;
  localparam logic [17:0] KBU = 18'd132252;
  localparam logic [17:0] KYR = 18'd16843;
  localparam logic [17:0] KYG = 18'd33030;
  localparam logic [17:0] KYB = 18'd6423;
  localparam logic [17:0] KUR = 18'd9699;
  localparam logic [17:0] KUG = 18'd19071;
  localparam logic [17:0] KUB = 18'd28770;
  localparam logic [17:0] KVR = 18'd28770;
  localparam logic [17:0] KVG = 18'd24117;
  localparam logic [17:0] KVB = 18'd4653;

  localparam logic [14:0] Full15    = 15'h7FFF;
  localparam logic [14:0] ChromaMax = 15'h3FFF;
  localparam logic [14:0] ChromaMin = 15'h4000;

  // multiples of 32767 used by the divide-by-32767 correction
  localparam logic [17:0] Div1 = 18'd32767;
  localparam logic [17:0] Div2 = 18'd65534;
  localparam logic [17:0] Div3 = 18'd98301;

  function automatic logic [32:0] umul_k(input logic [17:0] k, input logic [14:0] x);
    return {15'b0, k} * {18'b0, x};
  endfunction

  function automatic logic signed [33:0] smul_k(input logic [17:0] k,
                                                input logic signed [14:0] x);
    return $signed({16'b0, k}) * $signed({{19{x[14]}}, x});
  endfunction

endpackage

`default_nettype wire

// ----- design/rgb_yuv_color_converter_top.sv -----
// Top level of the BT.601 RGB/YUV colour converter: handshake, pipeline control, mode mux.
//
// Usage
//   Requests enter on in_valid_i/in_ready_o with all seven input fields; results leave on
//   out_valid_o/out_ready_i with all seven output fields. A transfer happens at a rising
//   edge where valid and ready are both high. cfg_we_i writes the direction bit from
//   cfg_wdata_i at once (0: RGB with alpha to YUV, 1: YUV to RGB); write it only while
//   no request is in flight. Each request captures the direction with its data.
//   Latency: nine register stages. Throughput: one request per cycle while the output
//   is not stalled, set by the nine-stage pipeline in which each stage holds one
//   multiplier or one wide add and compare.
//   Stalls: each stage carries a valid bit and advances when the stage after it is empty
//   or moving, so bubbles are squeezed out; with out_ready_i low the last stage holds its
//   result and in_ready_o drops only once every stage is full.
//   Reset (rst_ni low, asynchronous): all valid bits clear and direction returns to RGB
//   to YUV; pipeline payload is not reset. Fields the chosen mode does not produce
//   read as zero, and alpha_out_o is full scale in YUV to RGB mode.
`default_nettype none

module rgb_yuv_color_converter_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [14:0]        alpha_i,
  input  wire logic [14:0]        red_i,
  input  wire logic [14:0]        green_i,
  input  wire logic [14:0]        blue_i,
  input  wire logic [14:0]        luma_i,
  input  wire logic signed [14:0] chroma_u_i,
  input  wire logic signed [14:0] chroma_v_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [14:0]             alpha_out_o,
  output logic [14:0]             red_out_o,
  output logic [14:0]             green_out_o,
  output logic [14:0]             blue_out_o,
  output logic [14:0]             luma_out_o,
  output logic signed [14:0]      chroma_u_out_o,
  output logic signed [14:0]      chroma_v_out_o
);

  localparam int LastStg = ryc_pkg::NumStages - 1;

  logic                dir_q;
  ryc_pkg::stage_vec_t vld_q;
  ryc_pkg::stage_vec_t mode_q;
  ryc_pkg::stage_vec_t stage_en;

  logic [14:0]        yr_red, yr_green, yr_blue;
  logic [14:0]        ry_luma;
  logic signed [14:0] ry_u, ry_v;
  logic               in_acc, out_acc;

  // direction register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
    end else if (cfg_we_i) begin
      dir_q <= cfg_wdata_i;
    end
  end

  // a stage may load when it is empty or when its content moves on
  always_comb begin
    stage_en[LastStg] = !vld_q[LastStg] || out_ready_i;
    for (int k = LastStg - 1; k >= 0; k--) begin
      stage_en[k] = !vld_q[k] || stage_en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (stage_en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < ryc_pkg::NumStages; k++) begin
        if (stage_en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // carry the mode alongside each request
  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      mode_q[0] <= dir_q;
    end
    for (int k = 1; k < ryc_pkg::NumStages; k++) begin
      if (stage_en[k]) begin
        mode_q[k] <= mode_q[k-1];
      end
    end
  end

  ryc_rgb2yuv u_rgb2yuv (
    .clk_i      (clk_i),
    .en_i       (stage_en),
    .alpha_i    (alpha_i),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .luma_o     (ry_luma),
    .chroma_u_o (ry_u),
    .chroma_v_o (ry_v)
  );

  ryc_yuv2rgb u_yuv2rgb (
    .clk_i      (clk_i),
    .en_i       (stage_en),
    .luma_i     (luma_i),
    .chroma_u_i (chroma_u_i),
    .chroma_v_i (chroma_v_i),
    .red_o      (yr_red),
    .green_o    (yr_green),
    .blue_o     (yr_blue)
  );

  assign in_ready_o  = stage_en[0];
  assign out_valid_o = vld_q[LastStg];
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;

  // drop the fields the request's mode does not produce
  assign alpha_out_o    = mode_q[LastStg] ? ryc_pkg::Full15 : '0;
  assign red_out_o      = mode_q[LastStg] ? yr_red   : '0;
  assign green_out_o    = mode_q[LastStg] ? yr_green : '0;
  assign blue_out_o     = mode_q[LastStg] ? yr_blue  : '0;
  assign luma_out_o     = mode_q[LastStg] ? '0 : ry_luma;
  assign chroma_u_out_o = mode_q[LastStg] ? '0 : ry_u;
  assign chroma_v_out_o = mode_q[LastStg] ? '0 : ry_v;

  // a moving output never blocks the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_ready_i |-> in_ready_o)
    else $error("input stalled while output is taking results");

  // a full pipeline with a stalled output must refuse requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   ((&vld_q) && !out_ready_i) |-> !in_ready_o)
    else $error("request taken into a full stalled pipeline");

  // requests in flight change only by what enters and leaves
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   1'b1 |=> ($countones(vld_q) == $past($countones(vld_q))
                             + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("request lost or duplicated in the pipeline");

endmodule

`default_nettype wire

// ----- design/ryc_yuv2rgb.sv -----
// YUV to RGB datapath: four working stages, then a delay line to the common output stage.
`default_nettype none

module ryc_yuv2rgb (
  input  wire logic                      clk_i,
  input  wire ryc_pkg::stage_vec_t       en_i,
  input  wire logic [14:0]               luma_i,
  input  wire logic signed [14:0]        chroma_u_i,
  input  wire logic signed [14:0]        chroma_v_i,
  output logic [14:0]                    red_o,
  output logic [14:0]                    green_o,
  output logic [14:0]                    blue_o
);

  // c * 32767 as (c << 15) - c
  function automatic logic signed [49:0] mul_full(input logic signed [33:0] c);
    logic signed [49:0] sh;
    logic signed [49:0] ex;
    sh = $signed({c[33], c, 15'b0});
    ex = $signed({{16{c[33]}}, c});
    return sh - ex;
  endfunction

  // truncate by 2^30 and clamp to [0, 32767]; negatives clamp to zero
  function automatic logic [14:0] sat_rgb(input logic signed [49:0] n);
    logic [14:0] res;
    if (n[49]) begin
      res = '0;
    end else if (|n[48:45]) begin
      res = ryc_pkg::Full15;
    end else begin
      res = n[44:30];
    end
    return res;
  endfunction

  logic [32:0]        py1_q;
  logic signed [33:0] prv1_q, pgv1_q, pgu1_q, pbu1_q;
  logic [32:0]        py2_q;
  logic signed [33:0] prv2_q, cg2_q, pbu2_q;
  logic signed [49:0] rn3_q, gn3_q, bn3_q;
  logic signed [49:0] ypart;
  logic [14:0]        r4_q, g4_q, b4_q;
  logic [14:0]        r_dly_q [ryc_pkg::DlyLen];
  logic [14:0]        g_dly_q [ryc_pkg::DlyLen];
  logic [14:0]        b_dly_q [ryc_pkg::DlyLen];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      py1_q  <= ryc_pkg::umul_k(ryc_pkg::KY, luma_i);
      prv1_q <= ryc_pkg::smul_k(ryc_pkg::KRV, chroma_v_i);
      pgv1_q <= ryc_pkg::smul_k(ryc_pkg::KGV, chroma_v_i);
      pgu1_q <= ryc_pkg::smul_k(ryc_pkg::KGU, chroma_u_i);
      pbu1_q <= ryc_pkg::smul_k(ryc_pkg::KBU, chroma_u_i);
    end
    if (en_i[1]) begin
      py2_q  <= py1_q;
      prv2_q <= prv1_q;
      cg2_q  <= pgv1_q + pgu1_q;
      pbu2_q <= pbu1_q;
    end
    if (en_i[2]) begin
      rn3_q <= ypart + mul_full(prv2_q);
      gn3_q <= ypart - mul_full(cg2_q);
      bn3_q <= ypart + mul_full(pbu2_q);
    end
    if (en_i[3]) begin
      r4_q <= sat_rgb(rn3_q);
      g4_q <= sat_rgb(gn3_q);
      b4_q <= sat_rgb(bn3_q);
    end
    if (en_i[4]) begin
      r_dly_q[0] <= r4_q;
      g_dly_q[0] <= g4_q;
      b_dly_q[0] <= b4_q;
    end
    for (int k = 1; k < ryc_pkg::DlyLen; k++) begin
      if (en_i[4+k]) begin
        r_dly_q[k] <= r_dly_q[k-1];
        g_dly_q[k] <= g_dly_q[k-1];
        b_dly_q[k] <= b_dly_q[k-1];
      end
    end
  end

  assign ypart   = $signed({3'b0, py2_q, 14'b0});
  assign red_o   = r_dly_q[ryc_pkg::DlyLen-1];
  assign green_o = g_dly_q[ryc_pkg::DlyLen-1];
  assign blue_o  = b_dly_q[ryc_pkg::DlyLen-1];

endmodule

`default_nettype wire

// ----- design/ryc_rgb2yuv.sv -----
// RGB with alpha to YUV datapath: nine stages of products, sums and divide-by-32767 folding.
`default_nettype none

module ryc_rgb2yuv (
  input  wire logic                      clk_i,
  input  wire ryc_pkg::stage_vec_t       en_i,
  input  wire logic [14:0]               alpha_i,
  input  wire logic [14:0]               red_i,
  input  wire logic [14:0]               green_i,
  input  wire logic [14:0]               blue_i,
  output logic [14:0]                    luma_o,
  output logic signed [14:0]             chroma_u_o,
  output logic signed [14:0]             chroma_v_o
);

  function automatic logic [15:0] Div1_16();
    return ryc_pkg::Div1[15:0];
  endfunction

  function automatic logic [15:0] Div2_16();
    return ryc_pkg::Div2[15:0];
  endfunction

  // lane 0 is luma, lanes 1 and 2 are U and V
  logic [32:0]        prod_d [9];
  logic [32:0]        prod_q [9];
  logic signed [34:0] sum_d  [3];
  logic signed [34:0] sum_q  [3];
  logic signed [34:0] neg    [3];
  logic [30:0]        mag_q  [3];
  logic [45:0]        full_q [3];
  logic [30:0]        hi_q   [3];
  logic [31:0]        t_q    [3];
  logic [31:0]        quo_q  [3];
  logic [17:0]        t2_q   [3];
  logic [31:0]        div_lo [3];
  logic [1:0]         corr   [3];
  logic [29:0]        x2_q   [2];
  logic [14:0]        h3_q   [2];
  logic [15:0]        t3_q   [2];
  logic [15:0]        cmag   [2];
  logic [14:0]        chr_d  [2];
  logic [14:0]        chr_q  [2];
  logic [14:0]        a1_q, a2_q, a3_q;
  logic [1:0]         sgn3_q, sgn4_q, sgn5_q, sgn6_q, sgn7_q, sgn8_q;
  logic [14:0]        luma7_q, luma8_q, luma9_q;

  always_comb begin
    prod_d[0] = ryc_pkg::umul_k(ryc_pkg::KYR, red_i);
    prod_d[1] = ryc_pkg::umul_k(ryc_pkg::KYG, green_i);
    prod_d[2] = ryc_pkg::umul_k(ryc_pkg::KYB, blue_i);
    prod_d[3] = ryc_pkg::umul_k(ryc_pkg::KUR, red_i);
    prod_d[4] = ryc_pkg::umul_k(ryc_pkg::KUG, green_i);
    prod_d[5] = ryc_pkg::umul_k(ryc_pkg::KUB, blue_i);
    prod_d[6] = ryc_pkg::umul_k(ryc_pkg::KVR, red_i);
    prod_d[7] = ryc_pkg::umul_k(ryc_pkg::KVG, green_i);
    prod_d[8] = ryc_pkg::umul_k(ryc_pkg::KVB, blue_i);
  end

  always_comb begin
    sum_d[0] = $signed({2'b0, prod_q[0]}) + $signed({2'b0, prod_q[1]})
             + $signed({2'b0, prod_q[2]});
    sum_d[1] = $signed({2'b0, prod_q[5]}) - $signed({2'b0, prod_q[3]})
             - $signed({2'b0, prod_q[4]});
    sum_d[2] = $signed({2'b0, prod_q[6]}) - $signed({2'b0, prod_q[7]})
             - $signed({2'b0, prod_q[8]});
    for (int l = 0; l < 3; l++) begin
      neg[l] = -sum_q[l];
    end
  end

  // quotient by 32767 from the folded parts: remainder stays below 4 * 32767
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      corr[l]   = {1'b0, t2_q[l] >= ryc_pkg::Div1} + {1'b0, t2_q[l] >= ryc_pkg::Div2}
                + {1'b0, t2_q[l] >= ryc_pkg::Div3};
      div_lo[l] = quo_q[l] + {30'b0, corr[l]};
    end
  end

  // second divide by 32767 and sign restore; truncation is toward zero
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      cmag[c] = {1'b0, h3_q[c]}
              + {15'b0, t3_q[c] >= Div1_16()} + {15'b0, t3_q[c] >= Div2_16()};
      if (sgn8_q[c]) begin
        chr_d[c] = (cmag[c] > 16'd16384) ? ryc_pkg::ChromaMin : 15'(-cmag[c]);
      end else begin
        chr_d[c] = (cmag[c] > 16'd16383) ? ryc_pkg::ChromaMax : cmag[c][14:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= prod_d;
      a1_q   <= alpha_i;
    end
    if (en_i[1]) begin
      sum_q <= sum_d;
      a2_q  <= a1_q;
    end
    if (en_i[2]) begin
      for (int l = 0; l < 3; l++) begin
        mag_q[l] <= sum_q[l][34] ? neg[l][30:0] : sum_q[l][30:0];
      end
      sgn3_q <= {sum_q[2][34], sum_q[1][34]};
      a3_q   <= a2_q;
    end
    if (en_i[3]) begin
      for (int l = 0; l < 3; l++) begin
        full_q[l] <= {15'b0, mag_q[l]} * {31'b0, a3_q};
      end
      sgn4_q <= sgn3_q;
    end
    if (en_i[4]) begin
      for (int l = 0; l < 3; l++) begin
        hi_q[l] <= full_q[l][45:15];
        t_q[l]  <= {1'b0, full_q[l][45:15]} + {17'b0, full_q[l][14:0]};
      end
      sgn5_q <= sgn4_q;
    end
    if (en_i[5]) begin
      for (int l = 0; l < 3; l++) begin
        quo_q[l] <= {1'b0, hi_q[l]} + {15'b0, t_q[l][31:15]};
        t2_q[l]  <= {1'b0, t_q[l][31:15]} + {3'b0, t_q[l][14:0]};
      end
      sgn6_q <= sgn5_q;
    end
    if (en_i[6]) begin
      luma7_q <= div_lo[0][31] ? ryc_pkg::Full15 : div_lo[0][30:16];
      x2_q[0] <= div_lo[1][31:2];
      x2_q[1] <= div_lo[2][31:2];
      sgn7_q  <= sgn6_q;
    end
    if (en_i[7]) begin
      for (int c = 0; c < 2; c++) begin
        h3_q[c] <= x2_q[c][29:15];
        t3_q[c] <= {1'b0, x2_q[c][29:15]} + {1'b0, x2_q[c][14:0]};
      end
      luma8_q <= luma7_q;
      sgn8_q  <= sgn7_q;
    end
    if (en_i[8]) begin
      chr_q   <= chr_d;
      luma9_q <= luma8_q;
    end
  end

  assign luma_o     = luma9_q;
  assign chroma_u_o = $signed(chr_q[0]);
  assign chroma_v_o = $signed(chr_q[1]);

endmodule

`default_nettype wire

// ----- verif/rgb_yuv_color_converter_top_tb.sv -----
// Self-checking testbench for the BT.601 RGB/YUV colour converter top level.
module rgb_yuv_color_converter_top_tb;

  localparam int ClkPeriod     = 8;
  localparam int ResetCycles   = 8;
  localparam int IdlePercent   = 13;
  localparam int PhaseCount    = 6;
  localparam int PhaseRequests = 275;
  localparam int StallRequests = 40;
  localparam int StallCycles   = 150;
  // nine register stages; allow a little over that once everything has drained
  localparam int TailCycles    = 16;
  // longest correct silence is the receiver hold-off, so this is generous
  localparam int WatchdogLimit = 2000;
  localparam int MaxReports    = 100;

  // Q2.16 BT.601 coefficients, kept apart from the design's own copy
  localparam longint CoefY  = 76284;
  localparam longint CoefRV = 104595;
  localparam longint CoefGV = 53281;
  localparam longint CoefGU = 25625;
  localparam longint CoefBU = 132252;
  localparam longint CoefYR = 16843;
  localparam longint CoefYG = 33030;
  localparam longint CoefYB = 6423;
  localparam longint CoefUR = 9699;
  localparam longint CoefUG = 19071;
  localparam longint CoefUB = 28770;
  localparam longint CoefVR = 28770;
  localparam longint CoefVG = 24117;
  localparam longint CoefVB = 4653;

  localparam longint FullScale  = 32767;
  localparam longint ChromaHigh = 16383;
  localparam longint ChromaLow  = -16384;
  // divisors: 2^30 for YUV to RGB, 32767 * 2^16 for luma, 32767^2 * 4 for chroma
  localparam longint RgbDiv     = 64'sd1073741824;
  localparam longint LumaDiv    = 64'sd2147418112;
  localparam longint ChromaDiv  = 64'sd4294705156;

  typedef enum bit {
    RgbToYuv = 1'b0,
    YuvToRgb = 1'b1
  } direction_e;

  // one pixel; the same field set serves for requests and for results
  typedef struct packed {
    logic [14:0]        alpha;
    logic [14:0]        red;
    logic [14:0]        green;
    logic [14:0]        blue;
    logic [14:0]        luma;
    logic signed [14:0] chroma_u;
    logic signed [14:0] chroma_v;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  logic [14:0] alpha_i, red_i, green_i, blue_i, luma_i;
  logic signed [14:0] chroma_u_i, chroma_v_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [14:0] alpha_out_o, red_out_o, green_out_o, blue_out_o, luma_out_o;
  logic signed [14:0] chroma_u_out_o, chroma_v_out_o;

  // direction as the block should hold it, updated on every register write
  direction_e mode_now;
  // converted pixels still owed by the block, oldest first
  pixel_t     pending_pixels[$];
  int         error_count;
  int         quiet_cycles;
  // both sides run without gaps while this is set
  bit         steady_flow;
  // hold-off length handed to the receiver; the receiver clears it on pickup
  int         hold_off_req;

  rgb_yuv_color_converter_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .alpha_i        (alpha_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .luma_i         (luma_i),
    .chroma_u_i     (chroma_u_i),
    .chroma_v_i     (chroma_v_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .alpha_out_o    (alpha_out_o),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o),
    .luma_out_o     (luma_out_o),
    .chroma_u_out_o (chroma_u_out_o),
    .chroma_v_out_o (chroma_v_out_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Clamp a wide intermediate into the range of a result field.
  function automatic longint saturate(longint x, longint lo, longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  // Work out the converted pixel for one request in the given direction.
  // Fields the direction does not produce stay zero; alpha_out is full
  // scale only when converting to RGB. Signed longint division truncates
  // towards zero, which is what the block is meant to do.
  function automatic pixel_t convert_pixel(pixel_t p, direction_e mode);
    pixel_t q;
    longint y, u, v, y_term, r_num, g_num, b_num;
    longint a, r, g, b, y_sum, u_sum, v_sum;
    q = '0;
    if (mode == YuvToRgb) begin
      y      = longint'(p.luma);
      u      = longint'($signed(p.chroma_u));
      v      = longint'($signed(p.chroma_v));
      y_term = CoefY * y * 16384;
      r_num  = y_term + CoefRV * v * FullScale;
      g_num  = y_term - (CoefGV * v + CoefGU * u) * FullScale;
      b_num  = y_term + CoefBU * u * FullScale;
      q.alpha = 15'(FullScale);
      q.red   = 15'(saturate(r_num / RgbDiv, 0, FullScale));
      q.green = 15'(saturate(g_num / RgbDiv, 0, FullScale));
      q.blue  = 15'(saturate(b_num / RgbDiv, 0, FullScale));
    end else begin
      a     = longint'(p.alpha);
      r     = longint'(p.red);
      g     = longint'(p.green);
      b     = longint'(p.blue);
      y_sum = CoefYR * r + CoefYG * g + CoefYB * b;
      u_sum = CoefUB * b - CoefUR * r - CoefUG * g;
      v_sum = CoefVR * r - CoefVG * g - CoefVB * b;
      q.luma     = 15'(saturate((y_sum * a) / LumaDiv, 0, FullScale));
      q.chroma_u = 15'(saturate((u_sum * a) / ChromaDiv, ChromaLow, ChromaHigh));
      q.chroma_v = 15'(saturate((v_sum * a) / ChromaDiv, ChromaLow, ChromaHigh));
    end
    return q;
  endfunction

  function automatic pixel_t make_pixel(int a, int r, int g, int b, int y, int u, int v);
    pixel_t p;
    p.alpha    = 15'(a);
    p.red      = 15'(r);
    p.green    = 15'(g);
    p.blue     = 15'(b);
    p.luma     = 15'(y);
    p.chroma_u = 15'(u);
    p.chroma_v = 15'(v);
    return p;
  endfunction

  // Mostly uniform over all 15 bits, now and then a corner of the range.
  function automatic logic [14:0] pick_field();
    case ($urandom_range(31))
      0:       return 15'h0000;
      1:       return 15'h7FFF;
      2:       return 15'h4000;
      3:       return 15'h3FFF;
      4:       return 15'h0001;
      default: return 15'($urandom_range(32767));
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.alpha    = pick_field();
    p.red      = pick_field();
    p.green    = pick_field();
    p.blue     = pick_field();
    p.luma     = pick_field();
    p.chroma_u = pick_field();
    p.chroma_v = pick_field();
    return p;
  endfunction

  task automatic report_error(string msg);
    if (error_count < MaxReports) $display("ERROR: %s", msg);
    error_count++;
  endtask

  task automatic check_field(string name, longint got, longint want);
    if (got != want) begin
      report_error($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  // Offer one request and hold it until the block takes it. Entered and left
  // just after a rising edge. Ready is looked at on the falling edge, where
  // it already shows what the next rising edge will see.
  task automatic send_pixel(pixel_t p);
    bit taken;
    if (!steady_flow) begin
      while ($urandom_range(99) < IdlePercent) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    alpha_i    <= p.alpha;
    red_i      <= p.red;
    green_i    <= p.green;
    blue_i     <= p.blue;
    luma_i     <= p.luma;
    chroma_u_i <= p.chroma_u;
    chroma_v_i <= p.chroma_v;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      if (taken) pending_pixels.push_back(convert_pixel(p, mode_now));
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_pixels.size() != 0);
  endtask

  // Write the direction register only with the pipeline empty.
  task automatic set_direction(direction_e mode);
    wait_drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_now = mode;
  endtask

  // Black, white, transparent, primaries and partial alpha. The unused
  // luma/chroma inputs carry extremes in some requests to show they are ignored.
  task automatic test_rgb_to_yuv_corners();
    set_direction(RgbToYuv);
    send_pixel(make_pixel(32767, 0, 0, 0, 32767, 16383, -16384));
    send_pixel(make_pixel(32767, 32767, 32767, 32767, 0, -16384, 16383));
    send_pixel(make_pixel(0, 32767, 32767, 32767, 32767, -1, -1));
    send_pixel(make_pixel(32767, 32767, 0, 0, 0, 0, 0));
    send_pixel(make_pixel(32767, 0, 32767, 0, 0, 0, 0));
    send_pixel(make_pixel(32767, 0, 0, 32767, 0, 0, 0));
    send_pixel(make_pixel(16384, 16384, 16384, 16384, 1, 1, 1));
    send_pixel(make_pixel(1, 32767, 32767, 32767, 0, 0, 0));
    send_pixel(make_pixel(32767, 32767, 0, 32767, 0, 0, 0));
  endtask

  // Luma and chroma at their extremes, driving all three channels into
  // saturation at both ends; the unused RGB/alpha inputs vary between zero and full scale.
  task automatic test_yuv_to_rgb_corners();
    set_direction(YuvToRgb);
    send_pixel(make_pixel(32767, 32767, 32767, 32767, 0, 0, 0));
    send_pixel(make_pixel(0, 0, 0, 0, 32767, 0, 0));
    send_pixel(make_pixel(32767, 0, 32767, 0, 0, -16384, -16384));
    send_pixel(make_pixel(0, 32767, 0, 32767, 32767, 16383, 16383));
    send_pixel(make_pixel(0, 0, 0, 0, 32767, -16384, 16383));
    send_pixel(make_pixel(0, 0, 0, 0, 0, 16383, -16384));
    send_pixel(make_pixel(0, 0, 0, 0, 32767, -16384, -16384));
    send_pixel(make_pixel(0, 0, 0, 0, 16384, 0, 0));
    send_pixel(make_pixel(0, 0, 0, 0, 16384, -1, 1));
  endtask

  // Hold the receiver off while requests keep coming, so the pipeline fills
  // and in_ready_o drops; then pause the sender until it has all drained.
  task automatic test_output_stall();
    hold_off_req = StallCycles;
    for (int i = 0; i < StallRequests; i++) send_pixel(random_pixel());
    wait_drain();
  endtask

  // Random pixels in phases that alternate the direction; one phase runs
  // both sides flat out.
  task automatic test_random_pixels();
    for (int ph = 0; ph < PhaseCount; ph++) begin
      set_direction(ph % 2 == 0 ? YuvToRgb : RgbToYuv);
      steady_flow = (ph == 2);
      for (int i = 0; i < PhaseRequests; i++) send_pixel(random_pixel());
      steady_flow = 1'b0;
    end
  endtask

  // Receiver: random back-pressure, a long hold-off on request, none at all
  // during the steady phase.
  initial begin
    int hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req != 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (steady_flow) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  // Compare each result that will be taken at the coming rising edge with
  // the oldest owed pixel. Outputs are stable by the falling edge.
  always @(negedge clk_i) begin
    pixel_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.alpha    = alpha_out_o;
      got.red      = red_out_o;
      got.green    = green_out_o;
      got.blue     = blue_out_o;
      got.luma     = luma_out_o;
      got.chroma_u = chroma_u_out_o;
      got.chroma_v = chroma_v_out_o;
      if (pending_pixels.size() == 0) begin
        report_error("result with no request outstanding");
      end else begin
        want = pending_pixels.pop_front();
        check_field("alpha_out", got.alpha, want.alpha);
        check_field("red_out", got.red, want.red);
        check_field("green_out", got.green, want.green);
        check_field("blue_out", got.blue, want.blue);
        check_field("luma_out", got.luma, want.luma);
        check_field("chroma_u_out", $signed(got.chroma_u), $signed(want.chroma_u));
        check_field("chroma_v_out", $signed(got.chroma_v), $signed(want.chroma_v));
      end
    end
  end

  // Watchdog: give up once neither side has moved a request for too long.
  always @(negedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 1'b0;
    in_valid_i   = 1'b0;
    alpha_i      = '0;
    red_i        = '0;
    green_i      = '0;
    blue_i       = '0;
    luma_i       = '0;
    chroma_u_i   = '0;
    chroma_v_i   = '0;
    mode_now     = RgbToYuv;
    error_count  = 0;
    quiet_cycles = 0;
    steady_flow  = 1'b0;
    hold_off_req = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_rgb_to_yuv_corners();
    test_yuv_to_rgb_corners();
    test_output_stall();
    test_random_pixels();

    wait_drain();
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0 && pending_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
